/* sv/frt_pkg.sv */
// shared types and constants for the quarter-turn frame rotator
// used by frt_ctrl, frt_datapath and frame_rotate_quarter_turns_core
package frt_pkg;

	localparam int PIXEL_W    = 16;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int ROT_W      = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 2'd2;

	localparam logic [CFG_DATA_W-1:0] DIM_RESET = 7'd64;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_PULL = 1'b1;

	localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90   = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180  = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270  = 2'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic cfg_we;       // take the register write on the config channel
		logic push;         // store the accepted pixel (dropped in readout)
		logic addr_calc;    // form the store address of the next pixel
		logic ram_rd;       // read the store at the formed address
		logic load_result;  // move the read pixel to the output, advance
		logic load_empty;   // put an empty result on the output
	} frt_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic readout;      // frame complete, pulls return pixels
		logic slot_free;    // output register can take a beat this cycle
	} frt_status_t;

endpackage

/* sv/frame_rotate_quarter_turns_core.sv */
// top level of the quarter-turn frame rotator: sequencer plus datapath
// depends on frt_pkg, frt_ctrl, frt_datapath (and frt_ram below it)
//
// channel   direction  handshake           payload
// s_*       in         s_tvalid/s_tready   s_tdata in_pixel, s_tuser func
// m_*       out        m_tvalid/m_tready   m_tdata out_pixel, m_tlast last, m_tuser empty_res
// cfg_*     in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// a push is stored as it is accepted; a pull in readout steps through accept,
// address multiply, store read and output load, a pull while loading through
// accept and an empty-result load. a config write updates the frame pixel count
// through a register from the new dimensions. one item is in flight at a time
// and a stalled output holds the sequencer in place.
// reset clears control state only; the frame store needs no clearing pass.
module frame_rotate_quarter_turns_core #(
	parameter int MAX_DIM = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [frt_pkg::PIXEL_W-1:0]     s_tdata,   // [15:0] in_pixel
	input  logic                            s_tuser,   // [0] func
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [frt_pkg::PIXEL_W-1:0]     m_tdata,   // [15:0] out_pixel
	output logic                            m_tlast,
	output logic                            m_tuser,   // [0] empty_res
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [frt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [frt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import frt_pkg::*;

	frt_cmd_t    cmd;
	frt_status_t status;

	frt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.status   (status),
		.cmd      (cmd)
	);

	frt_datapath #(
		.MAX_DIM(MAX_DIM)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

/* sv/frt_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module frt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/frt_ctrl.sv */
// sequencer for the frame rotator: accepts beats and steps the datapath
// depends on frt_pkg
module frt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tuser,
	output logic                s_tready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  frt_pkg::frt_status_t status,
	output frt_pkg::frt_cmd_t   cmd
);

	import frt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CFG,
		ST_EMPTY,
		ST_ADDR,
		ST_READ,
		ST_DATA
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		cfg_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cfg_ready = 1'b1;
				s_tready  = !cfg_valid;
				if (cfg_valid) begin
					cmd.cfg_we = 1'b1;
					state_d    = ST_CFG;
				end else if (s_tvalid) begin
					if (s_tuser == FUNC_PUSH) begin
						cmd.push = 1'b1;
					end else if (status.readout) begin
						state_d = ST_ADDR;
					end else begin
						state_d = ST_EMPTY;
					end
				end
			end
			// pixel count follows the new dimensions in the cycle after
			ST_CFG: begin
				cfg_ready = 1'b1;
				if (cfg_valid) begin
					cmd.cfg_we = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (status.slot_free) begin
					cmd.load_empty = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_ADDR: begin
				cmd.addr_calc = 1'b1;
				state_d       = ST_READ;
			end
			ST_READ: begin
				cmd.ram_rd = 1'b1;
				state_d    = ST_DATA;
			end
			ST_DATA: begin
				if (status.slot_free) begin
					cmd.load_result = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/frt_datapath.sv */
// frame rotator datapath: config registers, counters, address math,
// frame store and output register; depends on frt_pkg and frt_ram
module frt_datapath #(
	parameter int MAX_DIM = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  frt_pkg::frt_cmd_t               cmd,
	output frt_pkg::frt_status_t            status,
	input  logic [frt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [frt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [frt_pkg::PIXEL_W-1:0]     s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [frt_pkg::PIXEL_W-1:0]     m_tdata,
	output logic                            m_tlast,
	output logic                            m_tuser
);

	import frt_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int AW = $clog2(MAX_DIM * MAX_DIM);
	localparam int CW = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int PW = 2 * DW;

	function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
		logic [DW-1:0] r;
		if (v == '0) begin
			r = DW'(1);
		end else if (32'(v) > 32'(MAX_DIM)) begin
			r = DW'(MAX_DIM);
		end else begin
			r = DW'(v);
		end
		return r;
	endfunction

	localparam logic [DW-1:0] DIM_RST   = clamp_dim(DIM_RESET);
	localparam logic [CW-1:0] TOTAL_RST = CW'(32'(DIM_RST) * 32'(DIM_RST));

	logic [DW-1:0]      width_q;
	logic [DW-1:0]      height_q;
	logic [ROT_W-1:0]   rot_q;
	logic [CW-1:0]      total_q;
	logic [CW-1:0]      load_cnt_q;
	logic [DW-1:0]      col_q;
	logic [DW-1:0]      row_q;
	logic               readout_q;
	logic [AW-1:0]      addr_s1;
	logic               fin_s1;
	logic               out_valid_q;
	logic [PIXEL_W-1:0] out_pixel_q;
	logic               out_last_q;
	logic               out_empty_q;
	logic [PIXEL_W-1:0] ram_rdata;

	logic               turned;
	logic [DW-1:0]      dst_w;
	logic [DW-1:0]      dst_h;
	logic               col_end;
	logic               row_end;
	logic [DW-1:0]      row_sel;
	logic [DW-1:0]      col_sel;
	logic [PW-1:0]      addr_full;
	logic [CW-1:0]      load_cnt_inc;
	logic               cfg_hit;
	logic               push_en;

	assign turned  = (rot_q == ROT_90) || (rot_q == ROT_270);
	assign dst_w   = turned ? height_q : width_q;
	assign dst_h   = turned ? width_q : height_q;
	assign col_end = (col_q == dst_w - DW'(1));
	assign row_end = (row_q == dst_h - DW'(1));

	// source row and column of the destination pixel at (col_q, row_q)
	always_comb begin
		case (rot_q)
			ROT_90: begin
				row_sel = height_q - DW'(1) - col_q;
				col_sel = row_q;
			end
			ROT_180: begin
				row_sel = height_q - DW'(1) - row_q;
				col_sel = width_q - DW'(1) - col_q;
			end
			ROT_270: begin
				row_sel = col_q;
				col_sel = width_q - DW'(1) - row_q;
			end
			default: begin
				row_sel = row_q;
				col_sel = col_q;
			end
		endcase
	end

	assign addr_full    = PW'(row_sel) * PW'(width_q) + PW'(col_sel);
	assign load_cnt_inc = load_cnt_q + CW'(1);
	assign cfg_hit      = cmd.cfg_we && (cfg_index == CFG_FRAME_WIDTH ||
		cfg_index == CFG_FRAME_HEIGHT || cfg_index == CFG_ROTATION);
	assign push_en      = cmd.push && !readout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RST;
			height_q <= DIM_RST;
			rot_q    <= ROT_NONE;
			total_q  <= TOTAL_RST;
		end else begin
			total_q <= CW'(PW'(width_q) * PW'(height_q));
			if (cmd.cfg_we) begin
				case (cfg_index)
					CFG_FRAME_WIDTH:  width_q  <= clamp_dim(cfg_data);
					CFG_FRAME_HEIGHT: height_q <= clamp_dim(cfg_data);
					CFG_ROTATION:     rot_q    <= cfg_data[ROT_W-1:0];
					default:          ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			readout_q  <= 1'b0;
		end else if (cfg_hit) begin
			load_cnt_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
			readout_q  <= 1'b0;
		end else if (push_en) begin
			load_cnt_q <= load_cnt_inc;
			if (load_cnt_inc >= total_q) begin
				readout_q <= 1'b1;
				col_q     <= '0;
				row_q     <= '0;
			end
		end else if (cmd.load_result) begin
			if (fin_s1) begin
				load_cnt_q <= '0;
				col_q      <= '0;
				row_q      <= '0;
				readout_q  <= 1'b0;
			end else if (col_end) begin
				col_q <= '0;
				row_q <= row_q + DW'(1);
			end else begin
				col_q <= col_q + DW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.addr_calc) begin
			addr_s1 <= AW'(addr_full);
			fin_s1  <= col_end && row_end;
		end
	end

	frt_ram #(
		.WIDTH(PIXEL_W),
		.DEPTH(MAX_DIM * MAX_DIM)
	) u_store (
		.clk  (clk),
		.we   (push_en),
		.waddr(load_cnt_q[AW-1:0]),
		.wdata(s_tdata),
		.re   (cmd.ram_rd),
		.raddr(addr_s1),
		.rdata(ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result || cmd.load_empty) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_pixel_q <= ram_rdata;
			out_last_q  <= fin_s1;
			out_empty_q <= 1'b0;
		end else if (cmd.load_empty) begin
			out_pixel_q <= '0;
			out_last_q  <= 1'b0;
			out_empty_q <= 1'b1;
		end
	end

	assign status.readout   = readout_q;
	assign status.slot_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pixel_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_empty_q;

endmodule

/* dv/testbench.sv */
// testbench for frame_rotate_quarter_turns_core: directed table, then random frames
// depends on frt_pkg and the core; expected beats come from an in-bench rotation predictor
`timescale 1ns / 100ps

module testbench;
	import frt_pkg::*;

	localparam int DIM_LIMIT  = 64;
	localparam int STORE_SIZE = DIM_LIMIT * DIM_LIMIT;
	localparam int RAND_ITEMS = 1750;
	localparam int DRAIN_CYC  = 8;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic               is_last;
		logic               is_empty;
	} pix_beat_t;

	typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_FIXED} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic                  fn;
		logic [PIXEL_W-1:0]    px;
		logic [CFG_DATA_W-1:0] w;
		logic [CFG_DATA_W-1:0] h;
		logic [ROT_W-1:0]      rot;
		pix_beat_t             fixed;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIXEL_W-1:0]    s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [PIXEL_W-1:0]    m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor state
	logic [PIXEL_W-1:0]    frame_mem [STORE_SIZE];
	int unsigned           load_cnt;
	int unsigned           rd_col;
	int unsigned           rd_row;
	bit                    in_readout;
	logic [CFG_DATA_W-1:0] cfg_w;
	logic [CFG_DATA_W-1:0] cfg_h;
	logic [ROT_W-1:0]      cfg_rot;

	pix_beat_t   expected_beats [$];
	int unsigned mismatches;
	int unsigned items_done;
	bit          idle_on;
	int unsigned stall_left;

	frame_rotate_quarter_turns_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#2_000_000;
		$display("[frame_rotate_quarter_turns_core] ERROR");
		$finish;
	end

	function automatic int unsigned clamped_dim(input logic [CFG_DATA_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DIM_LIMIT)
			return DIM_LIMIT;
		return v;
	endfunction

	function automatic stim_row_t mk_row(input row_kind_t kind, input logic fn,
			input logic [PIXEL_W-1:0] px, input logic [CFG_DATA_W-1:0] w,
			input logic [CFG_DATA_W-1:0] h, input logic [ROT_W-1:0] rot,
			input pix_beat_t fixed);
		stim_row_t r;
		r.kind  = kind;
		r.fn    = fn;
		r.px    = px;
		r.w     = w;
		r.h     = h;
		r.rot   = rot;
		r.fixed = fixed;
		return r;
	endfunction

	task automatic restart_frame();
		load_cnt   = 0;
		rd_col     = 0;
		rd_row     = 0;
		in_readout = 1'b0;
	endtask

	task automatic rotator_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_FRAME_WIDTH:  cfg_w = data;
			CFG_FRAME_HEIGHT: cfg_h = data;
			CFG_ROTATION:     cfg_rot = data[ROT_W-1:0];
			default: return;
		endcase
		restart_frame();
	endtask

	task automatic rotator_step(input logic fn, input logic [PIXEL_W-1:0] px,
			output bit has_res, output pix_beat_t res, output bit dropped);
		int unsigned w, h, dw, dh, x, y, addr;
		bit turned, fin;
		w       = clamped_dim(cfg_w);
		h       = clamped_dim(cfg_h);
		has_res = 1'b0;
		dropped = 1'b0;
		res     = '0;
		if (fn == FUNC_PUSH) begin
			if (in_readout) begin
				dropped = 1'b1;
			end else begin
				if (load_cnt < STORE_SIZE)
					frame_mem[load_cnt] = px;
				load_cnt++;
				if (load_cnt >= w * h) begin
					in_readout = 1'b1;
					rd_col     = 0;
					rd_row     = 0;
				end
			end
		end else if (!in_readout) begin
			has_res      = 1'b1;
			res.is_empty = 1'b1;
		end else begin
			turned = (cfg_rot == ROT_90) || (cfg_rot == ROT_270);
			dw     = turned ? h : w;
			dh     = turned ? w : h;
			x      = (rd_col >= dw) ? dw - 1 : rd_col;
			y      = (rd_row >= dh) ? dh - 1 : rd_row;
			case (cfg_rot)
				ROT_90:  addr = (h - 1 - x) * w + y;
				ROT_180: addr = (h - 1 - y) * w + (w - 1 - x);
				ROT_270: addr = x * w + (w - 1 - y);
				default: addr = y * w + x;
			endcase
			if (addr >= STORE_SIZE)
				addr = 0;
			fin         = (x == dw - 1) && (y == dh - 1);
			has_res     = 1'b1;
			res.pixel   = frame_mem[addr];
			res.is_last = fin;
			if (fin) begin
				restart_frame();
			end else if (x == dw - 1) begin
				rd_col = 0;
				rd_row = y + 1;
			end else begin
				rd_col = x + 1;
				rd_row = y;
			end
		end
	endtask

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatches < 50)
			$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input logic fn, input logic [PIXEL_W-1:0] px,
			input bit use_fixed, input pix_beat_t fixed_beat);
		bit has_res, dropped;
		pix_beat_t res;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= px;
		do @(posedge clk); while (!s_tready);
		rotator_step(fn, px, has_res, res, dropped);
		if (has_res)
			expected_beats.push_back(use_fixed ? fixed_beat : res);
		if (!dropped)
			items_done++;
		@(negedge clk);
	endtask

	// hold the pixel stream until every pending beat is back and the core is quiet
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (expected_beats.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	task automatic write_frame_regs(input logic [CFG_DATA_W-1:0] w,
			input logic [CFG_DATA_W-1:0] h, input logic [ROT_W-1:0] rot);
		logic [CFG_IDX_W-1:0]  regs [3];
		logic [CFG_DATA_W-1:0] vals [3];
		regs[0] = CFG_FRAME_WIDTH;
		regs[1] = CFG_FRAME_HEIGHT;
		regs[2] = CFG_ROTATION;
		vals[0] = w;
		vals[1] = h;
		// upper bits of the rotation register are don't-care
		vals[2] = {($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd0, rot};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			rotator_config(regs[i], vals[i]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// one well-formed frame with a little noise; may be cut short
	task automatic run_frame(input int unsigned npix, output bit cut);
		int unsigned stop_at;
		cut     = 1'b0;
		stop_at = 2 * npix;
		if ($urandom_range(0, 11) == 0) begin
			cut     = 1'b1;
			stop_at = $urandom_range(0, 2 * npix - 1);
		end
		for (int unsigned k = 0; k < stop_at; k++) begin
			if (k < npix) begin
				if ($urandom_range(0, 19) == 0)
					send_item(FUNC_PULL, 16'($urandom), 1'b0, '0);
				send_item(FUNC_PUSH, 16'($urandom), 1'b0, '0);
			end else begin
				if ($urandom_range(0, 19) == 0)
					send_item(FUNC_PUSH, 16'($urandom), 1'b0, '0);
				send_item(FUNC_PULL, 16'($urandom), 1'b0, '0);
			end
		end
	endtask

	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pix_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_beats.size() == 0) begin
				flag_mismatch("beat with nothing pending", m_tdata, 0);
			end else begin
				want = expected_beats.pop_front();
				if (m_tdata !== want.pixel)
					flag_mismatch("out_pixel", m_tdata, want.pixel);
				if (m_tlast !== want.is_last)
					flag_mismatch("last", m_tlast, want.is_last);
				if (m_tuser !== want.is_empty)
					flag_mismatch("empty_res", m_tuser, want.is_empty);
			end
		end
	end

	initial begin
		stim_row_t             dir_table [$];
		logic [CFG_DATA_W-1:0] w, h;
		logic [ROT_W-1:0]      rot;
		int unsigned           nfr;
		bit                    cut;

		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = FUNC_PUSH;
		m_tready   = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_FRAME_WIDTH;
		cfg_data   = '0;
		idle_on    = 1'b1;
		stall_left = 0;
		mismatches = 0;
		items_done = 0;
		for (int i = 0; i < STORE_SIZE; i++)
			frame_mem[i] = '0;
		cfg_w   = DIM_RESET;
		cfg_h   = DIM_RESET;
		cfg_rot = ROT_NONE;
		restart_frame();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// kind, func, pixel, width, height, rotation, fixed expectation
		dir_table.push_back(mk_row(ROW_PIX_FIXED, FUNC_PULL, 16'h0000, 0, 0, ROT_NONE,
			'{16'h0000, 1'b0, 1'b1}));
		dir_table.push_back(mk_row(ROW_CFG, FUNC_PUSH, 16'h0000, 7'd2, 7'd3, ROT_90, '0));
		dir_table.push_back(mk_row(ROW_PIX, FUNC_PUSH, 16'h0000, 0, 0, ROT_NONE, '0));
		dir_table.push_back(mk_row(ROW_PIX_FIXED, FUNC_PULL, 16'hFFFF, 0, 0, ROT_NONE,
			'{16'h0000, 1'b0, 1'b1}));
		dir_table.push_back(mk_row(ROW_PIX, FUNC_PUSH, 16'hFFFF, 0, 0, ROT_NONE, '0));
		dir_table.push_back(mk_row(ROW_PIX, FUNC_PUSH, 16'h8001, 0, 0, ROT_NONE, '0));
		dir_table.push_back(mk_row(ROW_PIX, FUNC_PUSH, 16'h7FFE, 0, 0, ROT_NONE, '0));
		dir_table.push_back(mk_row(ROW_PIX, FUNC_PUSH, 16'h1234, 0, 0, ROT_NONE, '0));
		dir_table.push_back(mk_row(ROW_PIX, FUNC_PUSH, 16'hFEDC, 0, 0, ROT_NONE, '0));
		// frame is full, this push is dropped
		dir_table.push_back(mk_row(ROW_PIX, FUNC_PUSH, 16'hDEAD, 0, 0, ROT_NONE, '0));
		for (int i = 0; i < 6; i++)
			dir_table.push_back(mk_row(ROW_PIX, FUNC_PULL, 16'h5A5A, 0, 0, ROT_NONE, '0));
		// zero width reads as one: a single pixel frame
		dir_table.push_back(mk_row(ROW_CFG, FUNC_PUSH, 16'h0000, 7'd0, 7'd1, ROT_270, '0));
		dir_table.push_back(mk_row(ROW_PIX, FUNC_PUSH, 16'hFFFF, 0, 0, ROT_NONE, '0));
		dir_table.push_back(mk_row(ROW_PIX_FIXED, FUNC_PULL, 16'h0000, 0, 0, ROT_NONE,
			'{16'hFFFF, 1'b1, 1'b0}));
		dir_table.push_back(mk_row(ROW_PIX_FIXED, FUNC_PULL, 16'h0000, 0, 0, ROT_NONE,
			'{16'h0000, 1'b0, 1'b1}));

		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_CFG) begin
				settle_idle();
				write_frame_regs(dir_table[i].w, dir_table[i].h, dir_table[i].rot);
			end else begin
				send_item(dir_table[i].fn, dir_table[i].px,
					dir_table[i].kind == ROW_PIX_FIXED, dir_table[i].fixed);
			end
		end

		items_done = 0;
		while (items_done < RAND_ITEMS) begin
			// tail of the run goes at full rate
			idle_on = (items_done < RAND_ITEMS - RAND_ITEMS / 8) && ($urandom_range(0, 7) != 0);
			case ($urandom_range(0, 15))
				0: begin
					w = 7'd64;
					h = 7'($urandom_range(1, 2));
				end
				1: begin
					w = 7'($urandom_range(1, 2));
					h = 7'd64;
				end
				2: begin
					w = 7'($urandom_range(65, 127));
					h = 7'($urandom_range(0, 1));
				end
				3: begin
					w = 7'($urandom_range(0, 1));
					h = 7'($urandom_range(65, 127));
				end
				4: begin
					w = 7'd0;
					h = 7'd0;
				end
				default: begin
					w = 7'($urandom_range(1, 8));
					h = 7'($urandom_range(1, 8));
				end
			endcase
			rot = 2'($urandom_range(0, 3));
			settle_idle();
			write_frame_regs(w, h, rot);
			nfr = $urandom_range(1, 3);
			cut = 1'b0;
			for (int f = 0; f < nfr && !cut; f++)
				run_frame(clamped_dim(w) * clamped_dim(h), cut);
		end

		settle_idle();
		if (mismatches == 0)
			$display("[frame_rotate_quarter_turns_core] OK");
		else
			$display("[frame_rotate_quarter_turns_core] ERROR");
		$finish;
	end

endmodule
